// ----- rtl/assert_macros.svh -----
// assertion macros for the deframer rtl
// no dependencies; included by the core top level, which carries concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ASSERT_SAME_CYCLE(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define ASSERT_NEXT_CYCLE(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lpfd_pkg.sv -----
// shared types, constants and register codes for the frame deframer
// no dependencies; imported by every rtl module of the block
package lpfd_pkg;

   // field widths
   localparam int BYTE_WIDTH        = 8;
   localparam int LENGTH_WIDTH      = 16;
   localparam int RSP_COUNT_WIDTH   = 32;
   localparam int CSR_DATA_WIDTH    = 32;
   localparam int CSR_ADDR_WIDTH    = 4;
   localparam int CSR_INDEX_WIDTH   = 2;

   // default counter width inside the block
   localparam int COUNTER_WIDTH_DEFAULT = 32;

   // register reset values
   localparam logic [BYTE_WIDTH-1:0]   FIRST_MAGIC_RESET  = 8'h94;
   localparam logic [BYTE_WIDTH-1:0]   SECOND_MAGIC_RESET = 8'hC3;
   localparam logic [LENGTH_WIDTH-1:0] MAX_LENGTH_RESET   = 16'd512;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FIRST_MAGIC  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SECOND_MAGIC = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_LENGTH   = 2'd2;

   // input command codes
   localparam logic CMD_FEED  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // framing states
   typedef enum logic [2:0] {
      ST_HUNT   = 3'd0,
      ST_MAGIC1 = 3'd1,
      ST_MAGIC2 = 3'd2,
      ST_LENHI  = 3'd3,
      ST_BODY   = 3'd4
   } hunt_state_type;

   // configuration register set
   typedef struct packed {
      logic [BYTE_WIDTH-1:0]   first_magic;
      logic [BYTE_WIDTH-1:0]   second_magic;
      logic [LENGTH_WIDTH-1:0] max_length;
   } cfg_type;

   // input item
   typedef struct packed {
      logic                  cmd;
      logic [BYTE_WIDTH-1:0] rx_byte;
   } req_item_type;

   // result item
   typedef struct packed {
      logic                       data_valid;
      logic [BYTE_WIDTH-1:0]      data_byte;
      logic                       frame_last;
      logic                       empty_frame;
      logic [LENGTH_WIDTH-1:0]    frame_length;
      logic [RSP_COUNT_WIDTH-1:0] frames_count;
      logic [RSP_COUNT_WIDTH-1:0] dropped_count;
      logic [RSP_COUNT_WIDTH-1:0] oversize_count;
   } rsp_item_type;

endpackage

// ----- rtl/lpfd_csr.sv -----
// configuration registers behind the apb-style port
// depends on lpfd_pkg
module lpfd_csr
   import lpfd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type                    cfg_ff;
   cfg_type                    cfg_in;
   logic                       wr_en;
   logic [CSR_INDEX_WIDTH-1:0] reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en     = psel && penable && pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_FIRST_MAGIC:  cfg_in.first_magic  = pwdata[BYTE_WIDTH-1:0];
            REG_SECOND_MAGIC: cfg_in.second_magic = pwdata[BYTE_WIDTH-1:0];
            REG_MAX_LENGTH:   cfg_in.max_length   = pwdata[LENGTH_WIDTH-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_magic  <= FIRST_MAGIC_RESET;
         cfg_ff.second_magic <= SECOND_MAGIC_RESET;
         cfg_ff.max_length   <= MAX_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_index)
         REG_FIRST_MAGIC:  prdata = CSR_DATA_WIDTH'(cfg_ff.first_magic);
         REG_SECOND_MAGIC: prdata = CSR_DATA_WIDTH'(cfg_ff.second_magic);
         REG_MAX_LENGTH:   prdata = CSR_DATA_WIDTH'(cfg_ff.max_length);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/lpfd_engine.sv -----
// framing state machine, length tracking and counters; one byte per step
// depends on lpfd_pkg; result is combinational from state and the current item
module lpfd_engine
   import lpfd_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   hunt_state_type           state_ff;
   hunt_state_type           state_in;
   logic [BYTE_WIDTH-1:0]    len_high_ff;
   logic [BYTE_WIDTH-1:0]    len_high_in;
   logic [LENGTH_WIDTH-1:0]  decl_ff;
   logic [LENGTH_WIDTH-1:0]  decl_in;
   logic [LENGTH_WIDTH-1:0]  recv_ff;
   logic [LENGTH_WIDTH-1:0]  recv_in;
   logic [COUNTER_WIDTH-1:0] frames_ff;
   logic [COUNTER_WIDTH-1:0] frames_in;
   logic [COUNTER_WIDTH-1:0] dropped_ff;
   logic [COUNTER_WIDTH-1:0] dropped_in;
   logic [COUNTER_WIDTH-1:0] oversize_ff;
   logic [COUNTER_WIDTH-1:0] oversize_in;

   logic                     clear;
   logic [LENGTH_WIDTH-1:0]  header_len;
   logic [LENGTH_WIDTH-1:0]  recv_inc;
   logic                     body_done;
   logic                     too_long;
   logic [1:0]               drop_n;
   logic                     frame_inc;
   logic                     over_inc;
   logic                     body_valid;
   logic                     last;
   logic                     empty;
   logic [63:0]              frames_wide;
   logic [63:0]              dropped_wide;
   logic [63:0]              oversize_wide;

   assign clear      = (item.cmd == CMD_CLEAR);
   assign header_len = {len_high_ff, item.rx_byte};
   assign too_long   = header_len > cfg.max_length;
   assign recv_inc   = recv_ff + LENGTH_WIDTH'(1);
   assign body_done  = recv_inc >= decl_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      if (clear) begin
         state_in = ST_HUNT;
      end else begin
         case (state_ff)
            ST_HUNT: begin
               if (item.rx_byte == cfg.first_magic) state_in = ST_MAGIC1;
            end
            ST_MAGIC1: begin
               if (item.rx_byte == cfg.second_magic) state_in = ST_MAGIC2;
               else if (item.rx_byte != cfg.first_magic) state_in = ST_HUNT;
            end
            ST_MAGIC2: state_in = ST_LENHI;
            ST_LENHI: begin
               if (too_long) begin
                  // re-arm only when both magics are equal
                  state_in = (cfg.second_magic == cfg.first_magic) ? ST_MAGIC1 : ST_HUNT;
               end else if (header_len == '0) begin
                  state_in = ST_HUNT;
               end else begin
                  state_in = ST_BODY;
               end
            end
            // body, and any stray code behaves as body
            default: state_in = body_done ? ST_HUNT : ST_BODY;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      len_high_in = len_high_ff;
      decl_in     = decl_ff;
      recv_in     = recv_ff;
      drop_n      = 2'd0;
      frame_inc   = 1'b0;
      over_inc    = 1'b0;
      body_valid  = 1'b0;
      last        = 1'b0;
      empty       = 1'b0;
      case (state_ff)
         ST_HUNT: begin
            if (item.rx_byte != cfg.first_magic) drop_n = 2'd1;
         end
         ST_MAGIC1: begin
            if (item.rx_byte == cfg.second_magic) drop_n = 2'd0;
            else if (item.rx_byte == cfg.first_magic) drop_n = 2'd1;
            else drop_n = 2'd2;
         end
         ST_MAGIC2: len_high_in = item.rx_byte;
         ST_LENHI: begin
            if (too_long) begin
               over_inc = 1'b1;
               drop_n   = 2'd1;
            end else if (header_len == '0) begin
               frame_inc = 1'b1;
               decl_in   = '0;
               recv_in   = '0;
               empty     = 1'b1;
            end else begin
               decl_in = header_len;
               recv_in = '0;
            end
         end
         default: begin
            body_valid = 1'b1;
            recv_in    = recv_inc;
            if (body_done) begin
               last      = 1'b1;
               frame_inc = 1'b1;
               recv_in   = '0;
               decl_in   = '0;
            end
         end
      endcase

      // clear command wipes framing state and counters
      if (clear) begin
         len_high_in = '0;
         decl_in     = '0;
         recv_in     = '0;
         body_valid  = 1'b0;
         last        = 1'b0;
         empty       = 1'b0;
         frames_in   = '0;
         dropped_in  = '0;
         oversize_in = '0;
      end else begin
         frames_in   = frames_ff + COUNTER_WIDTH'(frame_inc);
         dropped_in  = dropped_ff + COUNTER_WIDTH'(drop_n);
         oversize_in = oversize_ff + COUNTER_WIDTH'(over_inc);
      end

      frames_wide   = 64'(frames_in);
      dropped_wide  = 64'(dropped_in);
      oversize_wide = 64'(oversize_in);

      result.data_valid     = body_valid;
      result.data_byte      = body_valid ? item.rx_byte : '0;
      result.frame_last     = last;
      result.empty_frame    = empty;
      result.frame_length   = body_valid ? decl_ff : decl_in;
      result.frames_count   = frames_wide[RSP_COUNT_WIDTH-1:0];
      result.dropped_count  = dropped_wide[RSP_COUNT_WIDTH-1:0];
      result.oversize_count = oversize_wide[RSP_COUNT_WIDTH-1:0];
   end

   // state registers, updated once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_HUNT;
         len_high_ff <= '0;
         decl_ff     <= '0;
         recv_ff     <= '0;
         frames_ff   <= '0;
         dropped_ff  <= '0;
         oversize_ff <= '0;
      end else if (step_en) begin
         state_ff    <= state_in;
         len_high_ff <= len_high_in;
         decl_ff     <= decl_in;
         recv_ff     <= recv_in;
         frames_ff   <= frames_in;
         dropped_ff  <= dropped_in;
         oversize_ff <= oversize_in;
      end
   end

endmodule

// ----- rtl/length_prefixed_frame_deframer_core.sv -----
// top level of the length-prefixed frame deframer: handshake and result register
// depends on lpfd_pkg, lpfd_csr, lpfd_engine and assert_macros.svh
//
//   port group   direction   handshake                payload
//   req_*        in          req_valid / req_stall    req_item (cmd, rx_byte)
//   rsp_*        out         rsp_valid / rsp_stall    rsp_item (data and counters)
//   csr_*        in/out      psel, penable, pready    paddr, pwdata, prdata
//
// one item per cycle while not stalled; each item gives one result in the cycle after it is taken.
// the framing step sits between the state registers and the result register.
// reset is synchronous and restores the configuration, state and result valid registers and clears all counters.
// a stalled result holds; a new item is still taken when the result is taken
// in the same cycle.
module length_prefixed_frame_deframer_core
   import lpfd_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_item_type              req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_item_type              rsp_item,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   cfg_type      cfg;
   rsp_item_type step_result;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         accept;

   lpfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   lpfd_engine #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept),
      .item    (req_item),
      .cfg     (cfg),
      .result  (step_result)
   );

   // handshake: stall only while a result is held back
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) rsp_valid_in = 1'b1;
      else if (rsp_stall) rsp_valid_in = rsp_valid_ff;
      else rsp_valid_in = 1'b0;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // checks
`include "assert_macros.svh"

   `ASSERT_NEXT_CYCLE(a_accept_gives_result, clock, reset, accept, rsp_valid, "accepted item gave no result")
   `ASSERT_SAME_CYCLE(a_last_is_body, clock, reset, rsp_valid && rsp_item.frame_last, rsp_item.data_valid, "frame end mark without body byte")
   `ASSERT_SAME_CYCLE(a_empty_no_data, clock, reset, rsp_valid && rsp_item.empty_frame, !rsp_item.data_valid && rsp_item.frame_length == '0, "empty frame carries data")
   `ASSERT_NEXT_CYCLE(a_clear_zeroes, clock, reset, accept && req_item.cmd == CMD_CLEAR, rsp_item.frames_count == '0 && rsp_item.dropped_count == '0 && rsp_item.oversize_count == '0, "clear left counters set")

endmodule
